// File: src/kcmc_pkg.sv
// Shared types and constants for the keypad code and mode controller.
// Depends on nothing; every other file in src uses it by scoped names.
`default_nettype none
package kcmc_pkg;

    // entry buffer depth and the digits a packed code can hold
    localparam int CODE_DIGITS   = 4;
    localparam int PACKED_DIGITS = 4;
    localparam int MATCH_DIGITS  = (CODE_DIGITS < PACKED_DIGITS) ? CODE_DIGITS : PACKED_DIGITS;
    localparam int LEN_W         = $clog2(CODE_DIGITS + 1);
    localparam int DIGIT_W       = 4;
    localparam int ENTRY_W       = CODE_DIGITS * DIGIT_W;

    // packed code register: count in 18:16, BCD digits in 15:0, first digit high
    localparam int CODE_W        = 19;
    localparam int COUNT_LSB     = 16;
    localparam int COUNT_W       = 3;
    localparam int WRONG_W       = 4;
    localparam int KEY_W         = 4;
    localparam int CFG_IDX_W     = 2;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 16;

    localparam logic [WRONG_W-1:0] WRONG_SAT = 4'd15;

    // key codes
    localparam logic [KEY_W-1:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [KEY_W-1:0] KEY_A         = 4'd10;
    localparam logic [KEY_W-1:0] KEY_B         = 4'd11;
    localparam logic [KEY_W-1:0] KEY_C         = 4'd12;
    localparam logic [KEY_W-1:0] KEY_D         = 4'd13;
    localparam logic [KEY_W-1:0] KEY_STAR      = 4'd14;
    localparam logic [KEY_W-1:0] KEY_HASH      = 4'd15;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WRONG   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTER_CODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_CODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_CODE = 2'd3;

    // configuration reset values
    localparam logic [WRONG_W-1:0] RST_MAX_WRONG    = 4'd3;
    localparam logic [CODE_W-1:0]  RST_ENTER_CODE   = 19'h11000;
    localparam logic [CODE_W-1:0]  RST_EXIT_CODE    = 19'h10000;
    localparam logic [CODE_W-1:0]  RST_SILENCE_CODE = 19'h41234;

    typedef enum logic [3:0] {
        MSG_NONE        = 4'd0,
        MSG_LOCKED      = 4'd1,
        MSG_NEED_MANUAL = 4'd2,
        MSG_RETRACT     = 4'd3,
        MSG_RAIN_NO_EXT = 4'd4,
        MSG_EXTEND      = 4'd5,
        MSG_FAN_ON      = 4'd6,
        MSG_FAN_OFF     = 4'd7,
        MSG_RAIN_NO_MAN = 4'd8,
        MSG_MANUAL      = 4'd9,
        MSG_AUTO        = 4'd10,
        MSG_SILENCED    = 4'd11,
        MSG_WRONG       = 4'd12
    } t_msg;

    typedef struct packed {
        t_msg message;
        logic manual_active;
        logic locked;
        logic rack_set;
        logic rack_extend;
        logic fan_set;
        logic fan_on;
        logic fan_override;
        logic buzzer_silenced;
        logic auto_recompute;
        logic buzzer_cut;
    } t_result;

endpackage
`default_nettype wire

// File: src/keypad_code_mode_controller.sv
// Keypad code and mode controller, top level.
// Depends on kcmc_pkg and kcmc_code_match.
//
// Usage:
//   Slave stream carries one decoded key press per transfer:
//     s_axis_tdata[3:0] key_code, [4] raining, [7:5] zero.
//   Master stream returns one result per key:
//     m_axis_tdata[3:0] message, [4] manual_active, [5] locked, [6] rack_set,
//     [7] rack_extend, [8] fan_set, [9] fan_on, [10] fan_override,
//     [11] buzzer_silenced, [12] auto_recompute, [13] buzzer_cut, [15:14] zero.
//   Configuration: i_cfg_we with i_cfg_index / i_cfg_data writes one register
//     per cycle (0 max wrong codes, 1 enter code, 2 exit code, 3 silence code).
//     Write only while no key is in flight.
// Timing:
//   A key is held in the input register; the mode/code update runs in
//   one pass of logic from there into the result register, which holds the
//   result; one key per cycle is sustained while m_axis_tready stays high.
// Reset (i_rst_n low, synchronous): clears mode, lock, wrong tally, fan
//   override, entry buffer and both pipeline valids; config takes defaults.
// Stall: when m_axis_tready is low the result holds, the input register
//   still fills once, then s_axis_tready drops until the result drains.
`default_nettype none
module keypad_code_mode_controller (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [kcmc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // key_code, raining
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // message, manual_active, locked, rack_set, rack_extend, fan_set, fan_on,
    // fan_override, buzzer_silenced, auto_recompute, buzzer_cut
    output logic [kcmc_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [kcmc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [kcmc_pkg::CODE_W-1:0]         i_cfg_data
);

    // configuration
    logic [kcmc_pkg::WRONG_W-1:0] r_max_wrong;
    logic [kcmc_pkg::CODE_W-1:0]  r_enter_code;
    logic [kcmc_pkg::CODE_W-1:0]  r_exit_code;
    logic [kcmc_pkg::CODE_W-1:0]  r_silence_code;

    // input register
    logic                         r_in_valid;
    logic [kcmc_pkg::KEY_W-1:0]   r_in_key;
    logic                         r_in_rain;

    // controller state
    logic                         r_manual, n_manual;
    logic                         r_lock, n_lock;
    logic [kcmc_pkg::WRONG_W-1:0] r_wrong, n_wrong;
    logic                         r_fan_ovr, n_fan_ovr;
    logic [kcmc_pkg::ENTRY_W-1:0] r_entry, n_entry;
    logic [kcmc_pkg::LEN_W-1:0]   r_len, n_len;

    // result register
    logic                         r_out_valid;
    kcmc_pkg::t_result            r_out, n_out;

    logic advance;
    logic match_enter, match_exit, match_silence;

    // advance the input register into the result register when there is room
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_wrong    <= kcmc_pkg::RST_MAX_WRONG;
            r_enter_code   <= kcmc_pkg::RST_ENTER_CODE;
            r_exit_code    <= kcmc_pkg::RST_EXIT_CODE;
            r_silence_code <= kcmc_pkg::RST_SILENCE_CODE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kcmc_pkg::CFG_MAX_WRONG:    r_max_wrong    <= i_cfg_data[kcmc_pkg::WRONG_W-1:0];
                kcmc_pkg::CFG_ENTER_CODE:   r_enter_code   <= i_cfg_data;
                kcmc_pkg::CFG_EXIT_CODE:    r_exit_code    <= i_cfg_data;
                kcmc_pkg::CFG_SILENCE_CODE: r_silence_code <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // input register: take a transfer whenever the slot is free or draining
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_key  <= s_axis_tdata[kcmc_pkg::KEY_W-1:0];
            r_in_rain <= s_axis_tdata[kcmc_pkg::KEY_W];
        end
    end

    // ------------------------------------------------------------------
    // code comparators, one per configured code
    // ------------------------------------------------------------------
    kcmc_code_match u_match_enter (
        .i_code  (r_enter_code),
        .i_entry (r_entry),
        .i_len   (r_len),
        .o_match (match_enter)
    );

    kcmc_code_match u_match_exit (
        .i_code  (r_exit_code),
        .i_entry (r_entry),
        .i_len   (r_len),
        .o_match (match_exit)
    );

    kcmc_code_match u_match_silence (
        .i_code  (r_silence_code),
        .i_entry (r_entry),
        .i_len   (r_len),
        .o_match (match_silence)
    );

    // ------------------------------------------------------------------
    // key decode and state update
    // ------------------------------------------------------------------
    always_comb begin
        logic [kcmc_pkg::WRONG_W-1:0] wrong_inc;
        wrong_inc = (r_wrong < kcmc_pkg::WRONG_SAT) ? r_wrong + 1'b1 : r_wrong;

        n_manual  = r_manual;
        n_lock    = r_lock;
        n_wrong   = r_wrong;
        n_fan_ovr = r_fan_ovr;
        n_entry   = r_entry;
        n_len     = r_len;
        n_out     = '0;
        n_out.message = kcmc_pkg::MSG_NONE;

        if (r_lock) begin
            // locked: answer every key and change nothing
            n_out.message = kcmc_pkg::MSG_LOCKED;
        end else if (r_in_key >= kcmc_pkg::KEY_A && r_in_key <= kcmc_pkg::KEY_D) begin
            if (!r_manual) begin
                n_out.message = kcmc_pkg::MSG_NEED_MANUAL;
            end else if (r_in_key == kcmc_pkg::KEY_A) begin
                n_out.rack_set = 1'b1;
                n_out.message  = kcmc_pkg::MSG_RETRACT;
            end else if (r_in_key == kcmc_pkg::KEY_B) begin
                if (r_in_rain) begin
                    n_out.message = kcmc_pkg::MSG_RAIN_NO_EXT;
                end else begin
                    n_out.rack_set    = 1'b1;
                    n_out.rack_extend = 1'b1;
                    n_out.message     = kcmc_pkg::MSG_EXTEND;
                end
            end else begin
                n_fan_ovr     = 1'b1;
                n_out.fan_set = 1'b1;
                n_out.fan_on  = (r_in_key == kcmc_pkg::KEY_C);
                n_out.message = (r_in_key == kcmc_pkg::KEY_C) ? kcmc_pkg::MSG_FAN_ON
                                                              : kcmc_pkg::MSG_FAN_OFF;
            end
        end else if (r_in_key <= kcmc_pkg::KEY_DIGIT_MAX) begin
            // append the digit; drop it once the buffer is full
            if (r_len < kcmc_pkg::LEN_W'(kcmc_pkg::CODE_DIGITS)) begin
                for (int i = 0; i < kcmc_pkg::CODE_DIGITS; i++) begin
                    if (r_len == kcmc_pkg::LEN_W'(i)) begin
                        n_entry[i*kcmc_pkg::DIGIT_W +: kcmc_pkg::DIGIT_W] = r_in_key;
                    end
                end
                n_len = r_len + 1'b1;
            end
        end else if (r_in_key == kcmc_pkg::KEY_STAR) begin
            n_entry = '0;
            n_len   = '0;
        end else begin
            // hash: enter beats exit, exit beats silence
            if (match_enter) begin
                if (r_in_rain) begin
                    n_out.message = kcmc_pkg::MSG_RAIN_NO_MAN;
                end else begin
                    n_manual      = 1'b1;
                    n_out.message = kcmc_pkg::MSG_MANUAL;
                end
            end else if (match_exit) begin
                n_manual             = 1'b0;
                n_fan_ovr            = 1'b0;
                n_out.auto_recompute = 1'b1;
                n_out.message        = kcmc_pkg::MSG_AUTO;
            end else if (match_silence) begin
                n_wrong               = '0;
                n_out.buzzer_silenced = 1'b1;
                n_out.message         = kcmc_pkg::MSG_SILENCED;
            end else begin
                n_wrong       = wrong_inc;
                n_out.message = kcmc_pkg::MSG_WRONG;
                if (wrong_inc >= r_max_wrong) begin
                    n_lock           = 1'b1;
                    n_out.buzzer_cut = 1'b1;
                end
            end
            n_entry = '0;
            n_len   = '0;
        end

        n_out.manual_active = n_manual;
        n_out.locked        = n_lock;
        n_out.fan_override  = n_fan_ovr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual  <= 1'b0;
            r_lock    <= 1'b0;
            r_wrong   <= '0;
            r_fan_ovr <= 1'b0;
            r_entry   <= '0;
            r_len     <= '0;
        end else if (advance) begin
            r_manual  <= n_manual;
            r_lock    <= n_lock;
            r_wrong   <= n_wrong;
            r_fan_ovr <= n_fan_ovr;
            r_entry   <= n_entry;
            r_len     <= n_len;
        end
    end

    // ------------------------------------------------------------------
    // result register: hold while the receiver stalls
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00,
                            r_out.buzzer_cut,
                            r_out.auto_recompute,
                            r_out.buzzer_silenced,
                            r_out.fan_override,
                            r_out.fan_on,
                            r_out.fan_set,
                            r_out.rack_extend,
                            r_out.rack_set,
                            r_out.locked,
                            r_out.manual_active,
                            r_out.message};

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_lock_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock |=> r_lock)
        else $error("lock flag cleared without reset");

    a_entry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= kcmc_pkg::LEN_W'(kcmc_pkg::CODE_DIGITS))
        else $error("entry length beyond buffer depth");

    a_cut_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.buzzer_cut |-> r_out.locked && r_lock)
        else $error("buzzer cut without lock");

    a_cmd_qualified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out.rack_extend || r_out.rack_set)
                        && (!r_out.fan_on || r_out.fan_set))
        else $error("rack or fan value without its set strobe");

endmodule
`default_nettype wire

// File: src/kcmc_code_match.sv
// Compares the digit entry buffer against one packed code register.
// Depends on kcmc_pkg for widths and digit counts.
`default_nettype none
module kcmc_code_match (
    input  wire logic [kcmc_pkg::CODE_W-1:0]  i_code,
    input  wire logic [kcmc_pkg::ENTRY_W-1:0] i_entry,  // digit 0 in the low nibble
    input  wire logic [kcmc_pkg::LEN_W-1:0]   i_len,
    output logic                              o_match
);

    logic [kcmc_pkg::COUNT_W-1:0] count;

    assign count = i_code[kcmc_pkg::COUNT_LSB +: kcmc_pkg::COUNT_W];

    always_comb begin
        logic ok;
        ok = (count <= kcmc_pkg::COUNT_W'(kcmc_pkg::MATCH_DIGITS))
            && ({{(8 - kcmc_pkg::COUNT_W){1'b0}}, count} == 8'(i_len));
        for (int i = 0; i < kcmc_pkg::MATCH_DIGITS; i++) begin
            // only digits inside the code's count take part
            if (count > kcmc_pkg::COUNT_W'(i)) begin
                if (i_entry[i*kcmc_pkg::DIGIT_W +: kcmc_pkg::DIGIT_W]
                    != i_code[(kcmc_pkg::PACKED_DIGITS-1-i)*kcmc_pkg::DIGIT_W +:
                              kcmc_pkg::DIGIT_W]) begin
                    ok = 1'b0;
                end
            end
        end
        o_match = ok;
    end

endmodule
`default_nettype wire
